@@ rtl/esd_pkg.sv @@
// shared widths, character codes and the result beat type of the escape decoder
// no dependencies
`default_nettype none

package esd_pkg;

    localparam int BYTE_W  = 8;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // input op codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // character codes
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_SEVEN  = 8'h37;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_B   = 8'h42;
    localparam logic [BYTE_W-1:0] CH_UP_F   = 8'h46;
    localparam logic [BYTE_W-1:0] CH_UP_N   = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_UP_R   = 8'h52;
    localparam logic [BYTE_W-1:0] CH_UP_T   = 8'h54;
    localparam logic [BYTE_W-1:0] CH_UP_V   = 8'h56;
    localparam logic [BYTE_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [BYTE_W-1:0] CASE_DIFF = 8'd32;

    // decoded values of the letter escapes
    localparam logic [BYTE_W-1:0] VAL_BEL = 8'd7;
    localparam logic [BYTE_W-1:0] VAL_BS  = 8'd8;
    localparam logic [BYTE_W-1:0] VAL_FF  = 8'd12;
    localparam logic [BYTE_W-1:0] VAL_NL  = 8'd10;
    localparam logic [BYTE_W-1:0] VAL_CR  = 8'd13;
    localparam logic [BYTE_W-1:0] VAL_TAB = 8'd9;
    localparam logic [BYTE_W-1:0] VAL_VT  = 8'd11;

    localparam logic [1:0] MAX_DIGIT_IDX = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] char_value;
        logic              line_join;
        logic              last_of_run;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/esd_if.sv @@
// valid/ready channel interfaces for input and result beats of the escape decoder
// depends on esd_pkg
`default_nettype none

interface esd_in_if
    import esd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output op, output byte_in, input ready);
    modport sink   (input valid, input op, input byte_in, output ready);
endinterface

interface esd_out_if
    import esd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_value;
    logic              line_join;
    logic              last_of_run;

    modport source (output valid, output char_value, output line_join,
                    output last_of_run, input ready);
    modport sink   (input valid, input char_value, input line_join,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/c_escape_sequence_decoder.sv @@
// c literal escape decoder: input register, one-pass decode, result queue
// depends on esd_pkg and the channel interfaces in esd_if.sv
//
// usage
//   i_in  : input beats {op, byte_in}; op flush ends a literal and emits any
//           pending numeric escape
//   o_out : result beats {char_value, line_join, last_of_run}; an input beat
//           gives zero, one or two result beats, the last one flagged
//   cfg   : i_cfg_we / i_cfg_wdata write count_line_joins (reset 1); write
//           only while the block is idle
// timing
//   one input beat per cycle, sustained, as long as the result queue drains;
//   a beat waits in the input register until the decode writes its results
//   into a 4-entry queue; o_out presents the queue head whenever it is nonempty
//   the rate is set by the result port: a beat that yields two results needs
//   two pops, and input stalls once fewer than two queue slots are free
// reset
//   synchronous active low; empties the input register and the queue, returns
//   to plain-text mode and sets count_line_joins to 1
// stall
//   when o_out.ready is low, results wait in the queue; the input register
//   holds its beat and i_in.ready drops once the queue cannot take two more
`default_nettype none

module c_escape_sequence_decoder
    import esd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_wdata,
    esd_in_if.sink     i_in,
    esd_out_if.source  o_out
);

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX   = 3'd2,
        MODE_OCT   = 3'd3,
        MODE_SKIP  = 3'd4
    } t_mode;

    // upper-case fold for 0x61..0x7f
    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b);
        return (b >= CH_LOW_A && b <= CH_DEL) ? b - CASE_DIFF : b;
    endfunction

    // configuration
    logic r_count_joins;

    // input register
    logic              r_in_valid;
    logic              r_op;
    logic [BYTE_W-1:0] r_byte;

    // decode state
    t_mode             r_mode, n_mode;
    logic [BYTE_W-1:0] r_acc, n_acc;
    logic [1:0]        r_dig, n_dig;

    // result queue
    t_result           r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    // decode outputs
    logic [1:0]        w_nres;
    t_result           w_res0, w_res1;
    logic [BYTE_W-1:0] w_fold;
    logic [3:0]        w_hexv;
    logic              w_is_hex, w_is_oct;
    logic [BYTE_W-1:0] w_acc_hex, w_acc_oct;

    logic w_room;
    logic w_advance;
    logic w_pop;

    // the queue must take the worst case of two results
    assign w_room    = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign w_advance = r_in_valid && w_room;
    assign w_pop     = o_out.valid && o_out.ready;

    assign i_in.ready = !r_in_valid || w_advance;

    // digit classification
    always_comb begin
        w_fold   = fold(r_byte);
        w_hexv   = '0;
        w_is_hex = 1'b0;
        if (w_fold >= CH_UP_A && w_fold <= CH_UP_F) begin
            w_is_hex = 1'b1;
            w_hexv   = 4'(w_fold - CH_UP_A + 8'd10);
        end else if (w_fold >= CH_ZERO && w_fold <= CH_NINE) begin
            w_is_hex = 1'b1;
            w_hexv   = 4'(w_fold - CH_ZERO);
        end
        w_is_oct  = (r_byte >= CH_ZERO) && (r_byte <= CH_SEVEN);
        w_acc_hex = {r_acc[3:0], w_hexv};
        w_acc_oct = {r_acc[4:0], r_byte[2:0]};
    end

    // one-pass decode of the registered beat
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_dig  = r_dig;
        w_nres = 2'd0;
        w_res0 = '0;
        w_res1 = '0;

        if (r_op == OP_FLUSH) begin
            if (r_mode == MODE_HEX || r_mode == MODE_OCT) begin
                w_nres            = 2'd1;
                w_res0.char_value = r_acc;
            end
            n_mode = MODE_PLAIN;
            n_acc  = '0;
            n_dig  = '0;
        end else begin
            case (r_mode)
                MODE_SKIP: begin
                    n_mode = MODE_PLAIN;
                end
                MODE_ESC: begin
                    n_mode = MODE_PLAIN;
                    if (w_fold == CH_CR || w_fold == CH_LF) begin
                        if (w_fold == CH_CR) begin
                            n_mode = MODE_SKIP;
                        end
                        if (r_count_joins) begin
                            w_nres           = 2'd1;
                            w_res0.line_join = 1'b1;
                        end
                    end else if (w_fold == CH_UP_X) begin
                        n_mode = MODE_HEX;
                        n_acc  = '0;
                        n_dig  = '0;
                    end else if (w_is_oct) begin
                        n_mode = MODE_OCT;
                        n_acc  = {5'd0, r_byte[2:0]};
                        n_dig  = 2'd1;
                    end else begin
                        w_nres = 2'd1;
                        case (w_fold)
                            CH_UP_A: w_res0.char_value = VAL_BEL;
                            CH_UP_B: w_res0.char_value = VAL_BS;
                            CH_UP_F: w_res0.char_value = VAL_FF;
                            CH_UP_N: w_res0.char_value = VAL_NL;
                            CH_UP_R: w_res0.char_value = VAL_CR;
                            CH_UP_T: w_res0.char_value = VAL_TAB;
                            CH_UP_V: w_res0.char_value = VAL_VT;
                            default: w_res0.char_value = r_byte;
                        endcase
                    end
                end
                MODE_HEX, MODE_OCT: begin
                    if ((r_mode == MODE_HEX) ? w_is_hex : w_is_oct) begin
                        n_acc = (r_mode == MODE_HEX) ? w_acc_hex : w_acc_oct;
                        if (r_dig >= MAX_DIGIT_IDX) begin
                            // third digit closes the escape at once
                            w_nres            = 2'd1;
                            w_res0.char_value = n_acc;
                            n_mode            = MODE_PLAIN;
                            n_acc             = '0;
                            n_dig             = '0;
                        end else begin
                            n_dig = r_dig + 2'd1;
                        end
                    end else begin
                        // terminating byte: emit value, then treat byte as plain
                        w_res0.char_value = r_acc;
                        n_acc             = '0;
                        n_dig             = '0;
                        if (r_byte == CH_BSLASH) begin
                            w_nres = 2'd1;
                            n_mode = MODE_ESC;
                        end else begin
                            w_nres            = 2'd2;
                            w_res1.char_value = r_byte;
                            n_mode            = MODE_PLAIN;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_PLAIN;
                    if (r_byte == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        w_nres            = 2'd1;
                        w_res0.char_value = r_byte;
                    end
                end
            endcase
        end

        if (w_nres == 2'd1) begin
            w_res0.last_of_run = 1'b1;
        end
        if (w_nres == 2'd2) begin
            w_res1.last_of_run = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_joins <= 1'b1;
            r_in_valid    <= 1'b0;
            r_mode        <= MODE_PLAIN;
            r_acc         <= '0;
            r_dig         <= '0;
            r_wr          <= '0;
            r_rd          <= '0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_count_joins <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_mode <= n_mode;
                r_acc  <= n_acc;
                r_dig  <= n_dig;
                r_wr   <= r_wr + QPTR_W'(w_nres);
            end
            if (w_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (w_advance ? QCNT_W'(w_nres) : QCNT_W'(0))
                           - (w_pop ? QCNT_W'(1) : QCNT_W'(0));
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_op   <= i_in.op;
            r_byte <= i_in.byte_in;
        end
        if (w_advance && w_nres != 2'd0) begin
            r_q[r_wr] <= w_res0;
        end
        if (w_advance && w_nres == 2'd2) begin
            r_q[r_wr + QPTR_W'(1)] <= w_res1;
        end
    end

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.char_value  = r_q[r_rd].char_value;
    assign o_out.line_join   = r_q[r_rd].line_join;
    assign o_out.last_of_run = r_q[r_rd].last_of_run;

    // queue never overfills
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // pointers and fill count agree
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QPTR_W'(r_wr - r_rd) == r_cnt[QPTR_W-1:0])
        else $error("queue pointers out of step with count");

    // plain, escape and skip modes carry no leftover numeric state
    a_clean_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_PLAIN || r_mode == MODE_ESC || r_mode == MODE_SKIP)
        |-> (r_acc == '0 && r_dig == '0))
        else $error("stale accumulator outside numeric escape");

    // a flush always lands in plain mode
    a_flush_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_op == OP_FLUSH) |=> (r_mode == MODE_PLAIN))
        else $error("flush did not return to plain mode");

    // a line-join beat carries a zero character value
    a_join_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.line_join) |-> (o_out.char_value == '0))
        else $error("line join with nonzero value");

endmodule

`default_nettype wire

@@ dv/c_escape_sequence_decoder_tb.sv @@
// self-checking testbench for c_escape_sequence_decoder: directed and random literal bytes
// depends on esd_pkg and the channel interfaces in esd_if.sv
`timescale 1ns / 1ps

module c_escape_sequence_decoder_tb;
    import esd_pkg::*;

    // decoder modes tracked by the scoreboard side
    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX   = 3'd2,
        MODE_OCT   = 3'd3,
        MODE_SKIP  = 3'd4
    } t_mode;

    // one pending input beat
    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] byte_in;
    } t_lit_beat;

    localparam int DRAIN_CYCLES = 8;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;

    esd_in_if  in_ch ();
    esd_out_if out_ch ();

    c_escape_sequence_decoder uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // 12 ns period
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // known values on every input from time zero
    initial begin
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_BYTE;
        in_ch.byte_in  = '0;
        out_ch.ready   = 1'b0;
    end

    // ------------------------------------------------------------------
    // decode prediction: a private copy of the decoder state and register
    // ------------------------------------------------------------------
    t_mode             dec_mode;
    logic [BYTE_W-1:0] esc_acc;
    logic [1:0]        digit_cnt;
    logic              join_enable;

    t_result   expected_beats[$];   // decoded characters still owed by the block
    t_lit_beat pending_beats[$];    // literal bytes not yet presented
    int        queued_beats;
    int        error_count;

    function automatic t_result char_beat(logic [BYTE_W-1:0] value, logic join_flag);
        t_result r;
        r.char_value  = value;
        r.line_join   = join_flag;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // upper-case fold for the 0x61..0x7f range
    function automatic logic [BYTE_W-1:0] fold_case(logic [BYTE_W-1:0] b);
        return (b >= CH_LOW_A && b <= CH_DEL) ? b - CASE_DIFF : b;
    endfunction

    // works out the result beats of one accepted input beat
    task automatic decode_beat(input logic op, input logic [BYTE_W-1:0] b);
        t_result           run[$];
        logic [BYTE_W-1:0] f;
        logic [4:0]        digit;
        logic              reprocess;
        reprocess = 1'b0;
        if (op == OP_FLUSH) begin
            // only a numeric escape leaves a value behind; a lone backslash
            // or a pending skip is dropped
            if (dec_mode == MODE_HEX || dec_mode == MODE_OCT)
                run.push_back(char_beat(esc_acc, 1'b0));
            dec_mode  = MODE_PLAIN;
            esc_acc   = '0;
            digit_cnt = '0;
        end else begin
            case (dec_mode)
                MODE_SKIP: dec_mode = MODE_PLAIN;
                MODE_ESC: begin
                    f = fold_case(b);
                    dec_mode = MODE_PLAIN;
                    if (f == CH_CR || f == CH_LF) begin
                        // line continuation; cr also eats the byte after it
                        if (f == CH_CR)
                            dec_mode = MODE_SKIP;
                        if (join_enable)
                            run.push_back(char_beat('0, 1'b1));
                    end else if (f == CH_UP_A) run.push_back(char_beat(VAL_BEL, 1'b0));
                    else if (f == CH_UP_B) run.push_back(char_beat(VAL_BS, 1'b0));
                    else if (f == CH_UP_F) run.push_back(char_beat(VAL_FF, 1'b0));
                    else if (f == CH_UP_N) run.push_back(char_beat(VAL_NL, 1'b0));
                    else if (f == CH_UP_R) run.push_back(char_beat(VAL_CR, 1'b0));
                    else if (f == CH_UP_T) run.push_back(char_beat(VAL_TAB, 1'b0));
                    else if (f == CH_UP_V) run.push_back(char_beat(VAL_VT, 1'b0));
                    else if (f == CH_UP_X) begin
                        dec_mode  = MODE_HEX;
                        esc_acc   = '0;
                        digit_cnt = '0;
                    end else if (f >= CH_ZERO && f <= CH_SEVEN) begin
                        dec_mode  = MODE_OCT;
                        esc_acc   = f - CH_ZERO;
                        digit_cnt = 2'd1;
                    end else begin
                        // unknown escape yields the raw byte, not the folded one
                        run.push_back(char_beat(b, 1'b0));
                    end
                end
                MODE_HEX, MODE_OCT: begin
                    f = fold_case(b);
                    digit = 5'd16;
                    if (dec_mode == MODE_HEX) begin
                        if (f >= CH_UP_A && f <= CH_UP_F)
                            digit = 5'(f - CH_UP_A + 8'd10);
                        else if (f >= CH_ZERO && f <= CH_NINE)
                            digit = 5'(f - CH_ZERO);
                    end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
                        digit = 5'(b - CH_ZERO);
                    end
                    if (digit != 5'd16) begin
                        // accumulate modulo 256
                        esc_acc = (dec_mode == MODE_HEX) ? {esc_acc[3:0], digit[3:0]}
                                                         : {esc_acc[4:0], digit[2:0]};
                        if (digit_cnt >= MAX_DIGIT_IDX) begin
                            run.push_back(char_beat(esc_acc, 1'b0));
                            dec_mode  = MODE_PLAIN;
                            esc_acc   = '0;
                            digit_cnt = '0;
                        end else begin
                            digit_cnt++;
                        end
                    end else begin
                        // terminator: emit the value, then treat the byte as plain
                        run.push_back(char_beat(esc_acc, 1'b0));
                        esc_acc   = '0;
                        digit_cnt = '0;
                        reprocess = 1'b1;
                    end
                end
                default: reprocess = 1'b1;
            endcase
            if (reprocess) begin
                dec_mode = MODE_PLAIN;
                if (b == CH_BSLASH)
                    dec_mode = MODE_ESC;
                else
                    run.push_back(char_beat(b, 1'b0));
            end
        end
        if (run.size() > 0)
            run[run.size()-1].last_of_run = 1'b1;
        foreach (run[k])
            expected_beats.push_back(run[k]);
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of beats from the pending queue, random gaps between
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk) begin
        t_lit_beat nxt;
        logic      holding;
        logic      next_valid;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
            dec_mode    = MODE_PLAIN;
            esc_acc     = '0;
            digit_cnt   = '0;
            join_enable = 1'b1;
            expected_beats.delete();
        end else begin
            holding = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                decode_beat(in_ch.op, in_ch.byte_in);
                holding = 1'b0;
            end
            // a held beat keeps valid high without touching it
            if (!holding) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_beats.size() > 0) begin
                    nxt = pending_beats.pop_front();
                    in_ch.op      <= nxt.op;
                    in_ch.byte_in <= nxt.byte_in;
                    next_valid = 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    burst_left--;
                    // about a quarter of bursts run straight into the next one
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                in_ch.valid <= next_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: receiver stall pattern and result checking
    // ------------------------------------------------------------------
    int ready_mode;
    int ready_window;
    int ready_phase;

    always @(posedge clk) begin
        t_result got;
        t_result want;
        logic    next_ready;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            ready_mode   = 0;
            ready_window = 0;
            ready_phase  = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.char_value  = out_ch.char_value;
                got.line_join   = out_ch.line_join;
                got.last_of_run = out_ch.last_of_run;
                if (expected_beats.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %0h/%0b/%0b",
                             $time, got.char_value, got.line_join, got.last_of_run);
                    error_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (got.char_value !== want.char_value) begin
                        $display("%0t: char_value expected %0h actual %0h",
                                 $time, want.char_value, got.char_value);
                        error_count++;
                    end
                    if (got.line_join !== want.line_join) begin
                        $display("%0t: line_join expected %0b actual %0b",
                                 $time, want.line_join, got.line_join);
                        error_count++;
                    end
                    if (got.last_of_run !== want.last_of_run) begin
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, want.last_of_run, got.last_of_run);
                        error_count++;
                    end
                end
            end
            // stall pattern is redrawn whenever its random window runs out
            if (ready_window == 0) begin
                ready_mode   = $urandom_range(0, 3);
                ready_window = $urandom_range(16, 96);
            end else begin
                ready_window--;
            end
            ready_phase = (ready_phase + 1) % 3;
            case (ready_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = 1'($urandom_range(0, 1));
                2:       next_ready = (ready_phase == 0);
                default: next_ready = ($urandom_range(0, 7) == 0);
            endcase
            out_ch.ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [BYTE_W-1:0] b);
        t_lit_beat it;
        it.op      = OP_BYTE;
        it.byte_in = b;
        pending_beats.push_back(it);
        queued_beats++;
    endtask

    task automatic add_flush();
        t_lit_beat it;
        it.op      = OP_FLUSH;
        it.byte_in = 8'($urandom_range(0, 255));
        pending_beats.push_back(it);
        queued_beats++;
    endtask

    // 0..21 over "0-9", "a-f", "A-F"
    function automatic logic [BYTE_W-1:0] hex_digit_char(int unsigned n);
        if (n < 10)
            return CH_ZERO + 8'(n);
        else if (n < 16)
            return CH_LOW_A + 8'(n - 10);
        else
            return CH_UP_A + 8'(n - 16);
    endfunction

    function automatic logic [BYTE_W-1:0] letter_escape_char();
        logic [BYTE_W-1:0] c;
        case ($urandom_range(0, 6))
            0:       c = CH_UP_A;
            1:       c = CH_UP_B;
            2:       c = CH_UP_F;
            3:       c = CH_UP_N;
            4:       c = CH_UP_R;
            5:       c = CH_UP_T;
            default: c = CH_UP_V;
        endcase
        return $urandom_range(0, 1) ? c + CASE_DIFF : c;
    endfunction

    // mostly well-formed escapes with random content, some noise
    task automatic add_random_literal(input int target);
        int unsigned pick;
        int unsigned ndig;
        logic [BYTE_W-1:0] b;
        queued_beats = 0;
        while (queued_beats < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                repeat ($urandom_range(1, 4)) begin
                    b = 8'($urandom_range(0, 255));
                    add_byte((b == CH_BSLASH) ? CH_LOW_A : b);
                end
            end else if (pick < 40) begin
                add_byte(CH_BSLASH);
                add_byte(letter_escape_char());
            end else if (pick < 55) begin
                add_byte(CH_BSLASH);
                add_byte($urandom_range(0, 1) ? CH_UP_X : CH_UP_X + CASE_DIFF);
                ndig = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
                repeat (ndig) add_byte(hex_digit_char($urandom_range(0, 21)));
                if (ndig < 3) begin
                    if ($urandom_range(0, 3) == 0)
                        add_flush();
                    else
                        add_byte(8'($urandom_range(0, 255)));
                end
            end else if (pick < 68) begin
                add_byte(CH_BSLASH);
                ndig = $urandom_range(1, 3);
                repeat (ndig) add_byte(CH_ZERO + 8'($urandom_range(0, 7)));
                if (ndig < 3) begin
                    case ($urandom_range(0, 3))
                        0:       add_flush();
                        1:       add_byte(CH_NINE - 8'($urandom_range(0, 1)));
                        2:       add_byte(CH_BSLASH);
                        default: add_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end else if (pick < 76) begin
                add_byte(CH_BSLASH);
                if ($urandom_range(0, 1)) begin
                    add_byte(CH_LF);
                end else begin
                    add_byte(CH_CR);
                    add_byte($urandom_range(0, 1) ? CH_LF : 8'($urandom_range(0, 255)));
                end
            end else if (pick < 84) begin
                add_byte(CH_BSLASH);
                add_byte(8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                add_flush();
            end else if (pick < 94) begin
                // literal ends on a dangling backslash or a pending skip
                add_byte(CH_BSLASH);
                if ($urandom_range(0, 1))
                    add_byte(CH_CR);
                add_flush();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 7) == 0)
                        add_flush();
                    else if ($urandom_range(0, 3) == 0)
                        add_byte(CH_BSLASH);
                    else
                        add_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // everything presented and every owed result seen, then let the
    // input register and decode stage empty out
    task automatic wait_drained();
        do begin
            @(posedge clk);
            #1;
        end while (pending_beats.size() != 0 || in_ch.valid || expected_beats.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_join_cfg(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        join_enable = value;
    endtask

    initial begin
        error_count  = 0;
        queued_beats = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: byte extremes, letter escapes, both numeric kinds at full
        // length, empty hex escape, octal cut short by a backslash, both line
        // joins, and a flush of a pending escape (line joins on from reset)
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CH_BSLASH); add_byte(CH_LOW_A);
        add_byte(CH_BSLASH); add_byte(CH_UP_N);
        add_byte(CH_BSLASH); add_byte(CH_UP_X + CASE_DIFF);
        add_byte(CH_LOW_A + 8'd5); add_byte(CH_UP_F); add_byte(CH_ZERO + 8'd1);
        add_byte(CH_BSLASH); add_byte(CH_SEVEN); add_byte(CH_SEVEN); add_byte(CH_SEVEN);
        add_byte(CH_BSLASH); add_byte(CH_UP_X); add_byte(CH_LOW_A + 8'd6);
        add_byte(CH_BSLASH); add_byte(CH_ZERO + 8'd1);
        add_byte(CH_BSLASH); add_byte(CH_LF);
        add_byte(CH_BSLASH); add_byte(CH_CR); add_byte(CH_LOW_A + 8'd25);
        add_byte(CH_BSLASH); add_byte(CH_UP_X); add_byte(CH_NINE); add_flush();
        wait_drained();

        // random phases, line joins toggled between them
        write_join_cfg(1'b0);
        add_random_literal(500);
        wait_drained();

        write_join_cfg(1'b1);
        add_random_literal(500);
        wait_drained();

        write_join_cfg(1'b0);
        add_random_literal(500);
        add_flush();
        wait_drained();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
